### hw/rtl/ficb_pkg.sv
// ----------------------------------------------------------------------------
// ficb_pkg
// Shared types and constants of the frame input coalescing buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ficb_pkg;

    localparam int ACTION_W   = 2;
    localparam int CTL_W      = 2;
    localparam int FRAME_W    = 64;
    localparam int WORD_W     = 32;
    localparam int DELAY_W    = 8;
    localparam int NUM_CTL    = 4;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 192;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // request kinds
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COMMIT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // register index (paddr word index)
    localparam logic REG_COMMIT_DELAY = 1'b0;

    localparam logic [DELAY_W-1:0] COMMIT_DELAY_RST = 8'd5;

    // start bit is dropped from stored controller words
    localparam logic [WORD_W-1:0] START_MASK = 32'h0000_0010;

    // input tdata, lowest bits last in this list
    typedef struct packed {
        logic [5:0]         rsvd;
        logic [WORD_W-1:0]  pad_bits;
        logic [FRAME_W-1:0] frame;
        logic [CTL_W-1:0]   controller;
    } in_rec_t;

    // output tdata, out_frame in the lowest bits
    typedef struct packed {
        logic [WORD_W-1:0]  pad3;
        logic [WORD_W-1:0]  pad2;
        logic [WORD_W-1:0]  pad1;
        logic [WORD_W-1:0]  pad0;
        logic [FRAME_W-1:0] out_frame;
    } out_rec_t;

endpackage

`default_nettype wire

### hw/rtl/frame_input_coalescing_buffer.sv
// ----------------------------------------------------------------------------
// frame_input_coalescing_buffer
// Table of frame-tagged records, each holding four controller words. Store,
// commit and clear requests; aged or evicted records leave as results.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser=action, s_tdata=controller,frame,pad_bits
//  m_*       out  m_tvalid/m_tready  m_tdata=out_frame,pad0..pad3, m_tlast=last
//  apb       in   psel/penable       commit_delay at byte address 0
//
//  Every store, and every commit whose frame is not below the delay, scans
//  the frame tag RAM one slot per cycle through its single read port. A
//  store evicts the oldest record first when the table is full. A commit
//  emits its due records one by one, oldest first, with a scan before each.
//  Clear and unknown requests take no scan.
//  Reset: synchronous; slot valid/present flags are flops and clear at once,
//  no clearing pass. The RAMs need no reset.
//  Stalls: results go through an output register. A new request is taken
//  while a result waits; the block only stalls when it has a further result
//  and the previous one is still untaken.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_input_coalescing_buffer #(
    parameter int SLOTS = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input requests
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [1:0] controller, [65:2] frame, [97:66] pad_bits, [103:98] zero
    input  wire logic [ficb_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  wire logic [ficb_pkg::IN_TUSER_W-1:0]    s_tuser,
    // result records
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [63:0] out_frame, [95:64] pad0, [127:96] pad1, [159:128] pad2,
    // [191:160] pad3
    output logic      [ficb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                    m_tlast,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ficb_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ficb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ficb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    import ficb_pkg::*;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int WADDR_W = $clog2(SLOTS * NUM_CTL);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;   // walk the tag RAM
    localparam logic [2:0] ST_RDW   = 3'd2;   // fetch the four words
    localparam logic [2:0] ST_PUSH  = 3'd3;   // load output register
    localparam logic [2:0] ST_WRITE = 3'd4;   // store the word

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        delay_next = delay_reg;
        if (cfg_wr && (paddr[2] == REG_COMMIT_DELAY)) begin
            delay_next = pwdata[DELAY_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_COMMIT_DELAY)
                  ? {{(APB_DATA_W-DELAY_W){1'b0}}, delay_reg}
                  : '0;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [2:0]         state_reg, state_next;
    logic               valid_reg [SLOTS];
    logic               valid_next [SLOTS];
    logic [NUM_CTL-1:0] present_reg [SLOTS];
    logic [NUM_CTL-1:0] present_next [SLOTS];

    // latched request
    logic               commit_reg, commit_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [FRAME_W-1:0] limit_reg, limit_next;
    logic [CTL_W-1:0]   ctl_reg, ctl_next;
    logic [WORD_W-1:0]  word_reg, word_next;

    // scan bookkeeping
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               rd_v_reg, rd_v_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               have_match_reg, have_match_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic               have_free_reg, have_free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               have_old_reg, have_old_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [FRAME_W-1:0] best_frame_reg, best_frame_next;
    logic [CNT_W-1:0]   due_cnt_reg, due_cnt_next;

    // emit / write
    logic               emit_last_reg, emit_last_next;
    logic [2:0]         wcnt_reg, wcnt_next;
    logic [WORD_W-1:0]  pad_buf_reg [NUM_CTL];
    logic [WORD_W-1:0]  pad_buf_next [NUM_CTL];
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic               new_slot_reg, new_slot_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    out_rec_t           m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    // RAM ports
    logic [FRAME_W-1:0] frame_rdata;
    logic               frame_we;
    logic [WORD_W-1:0]  word_rdata;
    logic               word_we;
    logic [IDX_W+1:0]   word_waddr_full;
    logic [IDX_W+1:0]   word_raddr_full;

    in_rec_t            in_rec;
    logic               s_acc;
    logic               scan_start;
    logic [2:0]         wprev;
    logic [NUM_CTL-1:0] pres_q;

    assign in_rec   = in_rec_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign wprev    = wcnt_reg - 3'd1;
    assign pres_q   = present_reg[best_idx_reg];

    assign frame_we        = (state_reg == ST_WRITE) && new_slot_reg;
    assign word_we         = (state_reg == ST_WRITE);
    assign word_waddr_full = {wr_idx_reg, ctl_reg};
    assign word_raddr_full = {best_idx_reg, wcnt_reg[1:0]};

    ficb_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (SLOTS)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (frame_we),
        .wr_addr (wr_idx_reg),
        .wr_data (frame_reg),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (frame_rdata)
    );

    ficb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS * NUM_CTL)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (word_we),
        .wr_addr (word_waddr_full[WADDR_W-1:0]),
        .wr_data (word_reg),
        .rd_addr (word_raddr_full[WADDR_W-1:0]),
        .rd_data (word_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        present_next    = present_reg;
        commit_next     = commit_reg;
        frame_next      = frame_reg;
        limit_next      = limit_reg;
        ctl_next        = ctl_reg;
        word_next       = word_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_v_next       = 1'b0;
        rd_idx_next     = rd_idx_reg;
        have_match_next = have_match_reg;
        match_idx_next  = match_idx_reg;
        have_free_next  = have_free_reg;
        free_idx_next   = free_idx_reg;
        have_old_next   = have_old_reg;
        best_idx_next   = best_idx_reg;
        best_frame_next = best_frame_reg;
        due_cnt_next    = due_cnt_reg;
        emit_last_next  = emit_last_reg;
        wcnt_next       = wcnt_reg;
        pad_buf_next    = pad_buf_reg;
        wr_idx_next     = wr_idx_reg;
        new_slot_next   = new_slot_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        scan_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    commit_next = (s_tuser == ACT_COMMIT);
                    frame_next  = in_rec.frame;
                    ctl_next    = in_rec.controller;
                    word_next   = in_rec.pad_bits & ~START_MASK;
                    limit_next  = in_rec.frame - {{(FRAME_W-DELAY_W){1'b0}}, delay_reg};
                    priority if (s_tuser == ACT_STORE) begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end else if (s_tuser == ACT_COMMIT) begin
                        // nothing can be due while frame < delay
                        if (in_rec.frame >= {{(FRAME_W-DELAY_W){1'b0}}, delay_reg}) begin
                            scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end else if (s_tuser == ACT_CLEAR) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            valid_next[i]   = 1'b0;
                            present_next[i] = '0;
                        end
                    end else begin
                        // unknown request: dropped
                    end
                end
            end

            ST_SCAN: begin
                // issue next tag read
                if (scan_cnt_reg < CNT_W'(SLOTS)) begin
                    rd_v_next     = 1'b1;
                    rd_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end

                // judge the tag read last cycle
                if (rd_v_reg) begin
                    if (commit_reg) begin
                        if (valid_reg[rd_idx_reg] && (frame_rdata <= limit_reg)) begin
                            due_cnt_next = due_cnt_reg + CNT_W'(1);
                            if (!have_old_reg || (frame_rdata < best_frame_reg)) begin
                                have_old_next   = 1'b1;
                                best_idx_next   = rd_idx_reg;
                                best_frame_next = frame_rdata;
                            end
                        end
                    end else if (valid_reg[rd_idx_reg]) begin
                        if (frame_rdata == frame_reg) begin
                            have_match_next = 1'b1;
                            match_idx_next  = rd_idx_reg;
                        end else if (!have_old_reg || (frame_rdata < best_frame_reg)) begin
                            have_old_next   = 1'b1;
                            best_idx_next   = rd_idx_reg;
                            best_frame_next = frame_rdata;
                        end
                    end else if (!have_free_reg) begin
                        have_free_next = 1'b1;
                        free_idx_next  = rd_idx_reg;
                    end
                end

                if ((scan_cnt_reg == CNT_W'(SLOTS)) && !rd_v_reg) begin
                    wcnt_next = '0;
                    priority if (commit_reg) begin
                        emit_last_next = (due_cnt_reg == CNT_W'(1));
                        state_next     = have_old_reg ? ST_RDW : ST_IDLE;
                    end else if (have_match_reg) begin
                        wr_idx_next   = match_idx_reg;
                        new_slot_next = 1'b0;
                        state_next    = ST_WRITE;
                    end else if (have_free_reg) begin
                        wr_idx_next   = free_idx_reg;
                        new_slot_next = 1'b1;
                        state_next    = ST_WRITE;
                    end else begin
                        // table full: evict the oldest, then reuse its slot
                        wr_idx_next    = best_idx_reg;
                        new_slot_next  = 1'b1;
                        emit_last_next = 1'b1;
                        state_next     = ST_RDW;
                    end
                end
            end

            ST_RDW: begin
                // address k goes out at wcnt k, its data is captured at wcnt k+1
                if (wcnt_reg != 3'd0) begin
                    pad_buf_next[wprev[1:0]] = word_rdata;
                end
                if (wcnt_reg == 3'd4) begin
                    state_next = ST_PUSH;
                end else begin
                    wcnt_next = wcnt_reg + 3'd1;
                end
            end

            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next         = 1'b1;
                    m_last_next           = emit_last_reg;
                    m_data_next.out_frame = best_frame_reg;
                    m_data_next.pad0      = pres_q[0] ? pad_buf_reg[0] : '0;
                    m_data_next.pad1      = pres_q[1] ? pad_buf_reg[1] : '0;
                    m_data_next.pad2      = pres_q[2] ? pad_buf_reg[2] : '0;
                    m_data_next.pad3      = pres_q[3] ? pad_buf_reg[3] : '0;
                    valid_next[best_idx_reg]   = 1'b0;
                    present_next[best_idx_reg] = '0;
                    priority if (!commit_reg) begin
                        state_next = ST_WRITE;
                    end else if (emit_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_WRITE: begin
                valid_next[wr_idx_reg]   = 1'b1;
                present_next[wr_idx_reg] =
                    (new_slot_reg ? '0 : present_reg[wr_idx_reg])
                    | (NUM_CTL'(1) << ctl_reg);
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (scan_start) begin
            scan_cnt_next   = '0;
            rd_v_next       = 1'b0;
            have_match_next = 1'b0;
            have_free_next  = 1'b0;
            have_old_next   = 1'b0;
            due_cnt_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            delay_reg    <= COMMIT_DELAY_RST;
            m_tvalid_reg <= 1'b0;
            rd_v_reg     <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                valid_reg[i]   <= 1'b0;
                present_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            delay_reg    <= delay_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_v_reg     <= rd_v_next;
            valid_reg    <= valid_next;
            present_reg  <= present_next;
        end
    end

    always_ff @(posedge aclk) begin
        commit_reg     <= commit_next;
        frame_reg      <= frame_next;
        limit_reg      <= limit_next;
        ctl_reg        <= ctl_next;
        word_reg       <= word_next;
        scan_cnt_reg   <= scan_cnt_next;
        rd_idx_reg     <= rd_idx_next;
        have_match_reg <= have_match_next;
        match_idx_reg  <= match_idx_next;
        have_free_reg  <= have_free_next;
        free_idx_reg   <= free_idx_next;
        have_old_reg   <= have_old_next;
        best_idx_reg   <= best_idx_next;
        best_frame_reg <= best_frame_next;
        due_cnt_reg    <= due_cnt_next;
        emit_last_reg  <= emit_last_next;
        wcnt_reg       <= wcnt_next;
        pad_buf_reg    <= pad_buf_next;
        wr_idx_reg     <= wr_idx_next;
        new_slot_reg   <= new_slot_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

### hw/rtl/ficb_ram.sv
// ----------------------------------------------------------------------------
// ficb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ficb_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
